>>> hw/rtl/assert_macros.svh
// Assertion helpers. A synthesis build defines SYNTH and gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define BRF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BRF_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/brf_pkg.sv
package brf_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } brf_op_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_READ
  } brf_state_t;

  // controller -> datapath
  typedef struct packed {
    logic push;   // store data_in if there is room
    logic pop;    // remove the word at the read index
    logic flush;  // drop all unread words
    logic emit;   // produce a result this cycle
    logic last;   // that result closes the item
  } brf_cmd_t;

endpackage

>>> hw/rtl/brf_ctrl.sv
module brf_ctrl
  import brf_pkg::*;
#(
  parameter int MAX_READ = 64,
  localparam int RW = $clog2(MAX_READ + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    operation,
  input  logic [6:0]    read_length,
  input  logic [RW-1:0] stock,      // min(fill, MAX_READ)
  output logic          busy,
  output brf_cmd_t      cmd
);

  brf_state_t    state, state_next;
  logic [RW-1:0] remaining, remaining_next;
  logic [RW-1:0] len_sat;
  logic [RW-1:0] count;

  assign len_sat = (read_length > 7'(MAX_READ)) ? RW'(MAX_READ) : RW'(read_length);
  assign count   = (len_sat < stock) ? len_sat : stock;
  assign busy    = (state == CTL_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      remaining <= '0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
    end
  end

  always_comb begin
    cmd            = '0;
    state_next     = state;
    remaining_next = remaining;
    unique case (state)
      CTL_IDLE: begin
        if (start) begin
          cmd.emit = 1'b1;
          unique case (brf_op_t'(operation))
            OP_WRITE: begin
              cmd.push = 1'b1;
              cmd.last = 1'b1;
            end
            OP_READ: begin
              if (count == '0) begin
                cmd.last = 1'b1;
              end else begin
                cmd.pop        = 1'b1;
                cmd.last       = (count == RW'(1));
                remaining_next = count - RW'(1);
                if (count != RW'(1)) begin
                  state_next = CTL_READ;
                end
              end
            end
            OP_CLEAR: begin
              cmd.flush = 1'b1;
              cmd.last  = 1'b1;
            end
            OP_NOP: begin
              cmd.last = 1'b1;
            end
          endcase
        end
      end
      CTL_READ: begin
        cmd.emit       = 1'b1;
        cmd.pop        = 1'b1;
        cmd.last       = (remaining == RW'(1));
        remaining_next = remaining - RW'(1);
        if (remaining == RW'(1)) begin
          state_next = CTL_IDLE;
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/brf_datapath.sv
module brf_datapath
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64,
  localparam int RW = $clog2(MAX_READ + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  brf_cmd_t      cmd,
  input  logic [7:0]    data_in,
  input  logic          capacity_we,
  input  logic [8:0]    capacity,
  output logic [RW-1:0] stock,
  output logic          result_valid,
  output logic [7:0]    data_out,
  output logic          has_data,
  output logic          last,
  output logic          accepted,
  output logic [8:0]    fill_level,
  output logic [8:0]    free_space,
  output logic          is_empty,
  output logic          is_full
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = (CW > 9) ? CW : 9;
  localparam int SW = (CW > RW) ? CW : RW;

  logic [7:0]    byte_store [DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] wr_idx, wr_idx_next;
  logic [AW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] cap, cap_next;
  logic [CW-1:0] wr_inc, rd_inc;
  logic          room;

  assign room   = held < cap;  // also false when capacity is zero
  assign wr_inc = CW'(wr_idx) + CW'(1);
  assign rd_inc = CW'(rd_idx) + CW'(1);
  assign stock  = (SW'(held) >= SW'(MAX_READ)) ? RW'(MAX_READ) : RW'(held);

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    held_next   = held;
    cap_next    = cap;
    if (capacity_we) begin
      cap_next    = (VW'(capacity) > VW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity);
      wr_idx_next = '0;
      rd_idx_next = '0;
      held_next   = '0;
    end else if (cmd.push && room) begin
      wr_idx_next = (wr_inc >= cap) ? '0 : AW'(wr_inc);
      held_next   = held + CW'(1);
    end else if (cmd.pop) begin
      rd_idx_next = (rd_inc >= cap) ? '0 : AW'(rd_inc);
      held_next   = held - CW'(1);
    end else if (cmd.flush) begin
      rd_idx_next = wr_idx;
      held_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx       <= '0;
      rd_idx       <= '0;
      held         <= '0;
      cap          <= CW'(DEPTH);
      result_valid <= 1'b0;
    end else begin
      wr_idx       <= wr_idx_next;
      rd_idx       <= rd_idx_next;
      held         <= held_next;
      cap          <= cap_next;
      result_valid <= cmd.emit;
    end
  end

  // byte store: one write port, one registered read port at the read index
  always_ff @(posedge clk) begin
    if (cmd.push && room) begin
      byte_store[wr_idx] <= data_in;
    end
    rdata <= byte_store[rd_idx];
  end

  // status is taken after this result's update
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      has_data   <= cmd.pop;
      last       <= cmd.last;
      accepted   <= cmd.push && room;
      fill_level <= 9'(held_next);
      free_space <= (held_next < cap) ? 9'(cap - held_next) : '0;
      is_empty   <= (held_next == '0);
      is_full    <= (cap != '0) && (held_next >= cap);
    end
  end

  assign data_out = has_data ? rdata : 8'h00;

endmodule

>>> hw/rtl/byte_ring_fifo_core.sv
// Byte FIFO in a ring whose size is the capacity register (reset value DEPTH).
// Each command (start high while busy is low) yields its results starting on
// the cycle after acceptance, one word per cycle on result_valid, which lasts
// a single cycle and cannot be held off by the receiver. Write, clear, no-op
// and empty reads give one result and leave busy low, so such commands can be
// issued every cycle. A read of n bytes gives n results on consecutive cycles
// and keeps busy high until its last byte is popped, since the byte store
// has one read port delivering one byte per cycle. The store needs no clearing
// after reset; writing capacity (only while idle) empties the buffer.
`include "assert_macros.svh"

module byte_ring_fifo_core
  import brf_pkg::*;
#(
  parameter int DEPTH    = 256,
  parameter int MAX_READ = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] data_in,
  input  logic [6:0] read_length,
  input  logic       capacity_we,
  input  logic [8:0] capacity,
  output logic       result_valid,
  output logic [7:0] data_out,
  output logic       has_data,
  output logic       last,
  output logic       accepted,
  output logic [8:0] fill_level,
  output logic [8:0] free_space,
  output logic       is_empty,
  output logic       is_full
);

  localparam int RW = $clog2(MAX_READ + 1);

  brf_cmd_t      cmd;
  logic [RW-1:0] stock;

  brf_ctrl #(
    .MAX_READ(MAX_READ)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .read_length(read_length),
    .stock      (stock),
    .busy       (busy),
    .cmd        (cmd)
  );

  brf_datapath #(
    .DEPTH   (DEPTH),
    .MAX_READ(MAX_READ)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_in     (data_in),
    .capacity_we (capacity_we),
    .capacity    (capacity),
    .stock       (stock),
    .result_valid(result_valid),
    .data_out    (data_out),
    .has_data    (has_data),
    .last        (last),
    .accepted    (accepted),
    .fill_level  (fill_level),
    .free_space  (free_space),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

  `BRF_ASSERT_NEXT(a_cmd_gives_result, clk, rst, start && !busy, result_valid, "accepted command produced no result")
  `BRF_ASSERT_NEXT(a_burst_pops, clk, rst, busy, result_valid && has_data, "read burst skipped a cycle")
  `BRF_ASSERT_IMP(a_open_burst_busy, clk, rst, result_valid && !last, busy, "unfinished read while controller idle")
  `BRF_ASSERT_IMP(a_pop_no_push, clk, rst, cmd.pop, !cmd.push && !cmd.flush, "conflicting datapath commands")

endmodule

>>> tb/tb.sv
module tb
  import brf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH    = 256;
  localparam int MAX_READ = 64;
  localparam int AW       = $clog2(DEPTH);

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] operation = OP_NOP;
  logic [7:0] data_in = '0;
  logic [6:0] read_length = '0;
  logic       capacity_we = 1'b0;
  logic [8:0] capacity = '0;
  logic       result_valid;
  logic [7:0] data_out;
  logic       has_data;
  logic       last;
  logic       accepted;
  logic [8:0] fill_level;
  logic [8:0] free_space;
  logic       is_empty;
  logic       is_full;

  byte_ring_fifo_core #(
    .DEPTH(DEPTH),
    .MAX_READ(MAX_READ)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .data_in(data_in),
    .read_length(read_length),
    .capacity_we(capacity_we),
    .capacity(capacity),
    .result_valid(result_valid),
    .data_out(data_out),
    .has_data(has_data),
    .last(last),
    .accepted(accepted),
    .fill_level(fill_level),
    .free_space(free_space),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last_flag;
    logic       acc;
    logic [8:0] fill;
    logic [8:0] space;
    logic       empty_flag;
    logic       full_flag;
  } fifo_word_t;

  fifo_word_t  expected_words[$];
  int unsigned mismatch_count = 0;
  bit          no_gaps = 1'b0;

  // shadow copy of the ring
  logic [7:0]  ring_mem[DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned held;
  int unsigned cap_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned next_slot(int unsigned idx);
    return (idx + 1 >= cap_now) ? 0 : idx + 1;
  endfunction

  function automatic void push_status(logic [7:0] d, logic has, logic lst, logic acc);
    fifo_word_t w;
    w.data       = d;
    w.has        = has;
    w.last_flag  = lst;
    w.acc        = acc;
    w.fill       = 9'(held);
    w.space      = (held < cap_now) ? 9'(cap_now - held) : 9'd0;
    w.empty_flag = (held == 0);
    w.full_flag  = (cap_now != 0) && (held >= cap_now);
    expected_words.push_back(w);
  endfunction

  function automatic void predict_fifo_op(brf_op_t op, logic [7:0] din, logic [6:0] len);
    int unsigned n;
    int unsigned cnt;
    logic        acc;
    logic [7:0]  b;
    case (op)
      OP_WRITE: begin
        acc = 1'b0;
        if (cap_now != 0 && held < cap_now) begin
          ring_mem[AW'(wr_ptr)] = din;
          wr_ptr = next_slot(wr_ptr);
          held++;
          acc = 1'b1;
        end
        push_status(8'h00, 1'b0, 1'b1, acc);
      end
      OP_READ: begin
        n = (len > MAX_READ) ? MAX_READ : len;
        cnt = (n < held) ? n : held;
        if (cnt == 0) begin
          push_status(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
          for (int k = 0; k < cnt; k++) begin
            b = ring_mem[AW'(rd_ptr)];
            rd_ptr = next_slot(rd_ptr);
            held--;
            push_status(b, 1'b1, k == cnt - 1, 1'b0);
          end
        end
      end
      OP_CLEAR: begin
        rd_ptr = wr_ptr;
        held = 0;
        push_status(8'h00, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        push_status(8'h00, 1'b0, 1'b1, 1'b0);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [8:0] exp_v, logic [8:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    fifo_word_t w;
    if (!rst && result_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        mismatch_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("data_out", 9'(w.data), 9'(data_out));
        check_field("has_data", 9'(w.has), 9'(has_data));
        check_field("last", 9'(w.last_flag), 9'(last));
        check_field("accepted", 9'(w.acc), 9'(accepted));
        check_field("fill_level", w.fill, fill_level);
        check_field("free_space", w.space, free_space);
        check_field("is_empty", 9'(w.empty_flag), 9'(is_empty));
        check_field("is_full", 9'(w.full_flag), 9'(is_full));
      end
    end
  end

  // start low, junk on the command fields
  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      operation = brf_op_t'($urandom_range(3));
      data_in = 8'($urandom);
      read_length = 7'($urandom);
    end
  endtask

  task automatic pause_random();
    int unsigned roll;
    roll = $urandom_range(99);
    if (no_gaps || roll < 60) return;
    if (roll < 90) idle($urandom_range(3, 1));
    else idle($urandom_range(30, 5));
  endtask

  task automatic send_word(brf_op_t op, logic [7:0] din, logic [6:0] len);
    @(negedge clk);
    start = 1'b1;
    operation = op;
    data_in = din;
    read_length = len;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fifo_op(op, din, len);
    pause_random();
  endtask

  task automatic wait_drained();
    idle(1);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [8:0] v);
    wait_drained();
    @(negedge clk);
    capacity_we = 1'b1;
    capacity = v;
    cap_now = (v > DEPTH) ? DEPTH : v;
    wr_ptr = 0;
    rd_ptr = 0;
    held = 0;
    @(negedge clk);
    capacity_we = 1'b0;
    capacity = 9'($urandom);
  endtask

  task automatic test_empty_and_nop();
    send_word(OP_READ, 8'h00, 7'd1);
    send_word(OP_READ, 8'hFF, 7'd0);
    send_word(OP_NOP, 8'hFF, 7'd127);
    send_word(OP_CLEAR, 8'h00, 7'd64);
  endtask

  task automatic test_write_read_order();
    send_word(OP_WRITE, 8'h00, 7'd0);
    send_word(OP_WRITE, 8'hFF, 7'd127);
    send_word(OP_WRITE, 8'hA5, 7'd1);
    send_word(OP_WRITE, 8'h5A, 7'd64);
    send_word(OP_READ, 8'h00, 7'd2);
    // over-long length saturates
    send_word(OP_READ, 8'h00, 7'd127);
  endtask

  task automatic test_clear();
    send_word(OP_WRITE, 8'h3C, 7'd0);
    send_word(OP_WRITE, 8'hC3, 7'd0);
    send_word(OP_CLEAR, 8'h00, 7'd0);
    send_word(OP_READ, 8'h00, 7'd5);
    send_word(OP_WRITE, 8'h11, 7'd0);
    send_word(OP_READ, 8'h00, 7'd64);
  endtask

  task automatic test_capacity_limits();
    set_capacity(9'd0);
    send_word(OP_WRITE, 8'hFF, 7'd0);
    send_word(OP_READ, 8'h00, 7'd64);
    set_capacity(9'd2);
    send_word(OP_WRITE, 8'h01, 7'd0);
    send_word(OP_WRITE, 8'h02, 7'd0);
    send_word(OP_WRITE, 8'h03, 7'd0);
    send_word(OP_READ, 8'h00, 7'd1);
    send_word(OP_WRITE, 8'h04, 7'd0);
    send_word(OP_READ, 8'h00, 7'd3);
    // above DEPTH saturates
    set_capacity(9'd511);
    send_word(OP_WRITE, 8'h7E, 7'd0);
    send_word(OP_READ, 8'h00, 7'd1);
  endtask

  task automatic test_random_traffic();
    logic [8:0]  caps[5] = '{9'd7, 9'd1, 9'd300, 9'd0, 9'd13};
    int unsigned roll;
    int unsigned write_share;
    brf_op_t     op;
    logic [6:0]  len;
    for (int p = 0; p < 5; p++) begin
      set_capacity((p == 3) ? 9'($urandom_range(511)) : caps[p]);
      no_gaps = (p == 2);
      write_share = (p % 2 == 0) ? 60 : 35;
      for (int i = 0; i < 22; i++) begin
        roll = $urandom_range(99);
        if (roll < write_share) op = OP_WRITE;
        else if (roll < 90) op = OP_READ;
        else if (roll < 95) op = OP_CLEAR;
        else op = OP_NOP;
        roll = $urandom_range(99);
        if (roll < 70) len = 7'($urandom_range(8, 1));
        else if (roll < 85) len = 7'($urandom_range(64, 9));
        else len = 7'($urandom_range(127));
        send_word(op, 8'($urandom), len);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    wr_ptr = 0;
    rd_ptr = 0;
    held = 0;
    cap_now = DEPTH;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_nop();
    test_write_read_order();
    test_clear();
    test_capacity_limits();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/brf_pkg.sv
hw/rtl/brf_ctrl.sv
hw/rtl/brf_datapath.sv
hw/rtl/byte_ring_fifo_core.sv
tb/tb.sv
